// File: rtl/core/assert_macros.svh
// Assertion helpers for the RTL of this block; included by timed_action_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// When the first expression holds, the second holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/taq_pkg.sv
`default_nettype none

package taq_pkg;

    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_POP = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: rtl/core/timed_action_queue.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_mode, i_now_us, i_delay_us, i_action_id
// result    out        o_out_valid / i_out_stall  o_status, o_popped_action, o_popped_valid,
//                                                 o_wait_us, o_is_empty, o_entry_count
//
// An item passes through ST_APPLY, which applies the insert or remove across the row of cells,
// and then ST_WAIT, which forms the wait from the new head and in which the next item is accepted
// if the result register is free. The result is loaded into the output register as ST_WAIT ends.
// A stalled result register holds the block in ST_WAIT and stalls the input.
// Reset is synchronous and active low; it empties the queue.
`default_nettype none
`include "assert_macros.svh"

module timed_action_queue
    import taq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ACTION_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_mode,
    input  wire logic [TIME_W-1:0]         i_now_us,
    input  wire logic [DELAY_W-1:0]        i_delay_us,
    input  wire logic [ACTION_BITS-1:0]    i_action_id,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_status,
    output logic [ACTION_BITS-1:0]         o_popped_action,
    output logic                           o_popped_valid,
    output logic [TIME_W-1:0]              o_wait_us,
    output logic                           o_is_empty,
    output logic [$clog2(DEPTH + 1)-1:0]   o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    t_state                 r_state;
    t_state                 n_state;
    logic [1:0]             r_mode;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_due;
    logic [ACTION_BITS-1:0] r_id;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [1:0]             r_res_status;
    logic [ACTION_BITS-1:0] r_res_act;
    logic                   r_res_pvld;
    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic [ACTION_BITS-1:0] r_out_act;
    logic                   r_out_pvld;
    logic [TIME_W-1:0]      r_out_wait;
    logic                   r_out_empty;
    logic [CNT_W-1:0]       r_out_count;

    logic                   in_accept;
    logic                   out_free;
    logic                   do_add;
    logic                   do_pop;
    logic                   load_out;
    logic [TIME_W:0]        due_sum;
    logic [TIME_W-1:0]      head_wait;
    t_cell_ctrl             cell_ctrl;

    logic [TIME_W-1:0]      w_due [DEPTH];
    logic [ACTION_BITS-1:0] w_id  [DEPTH];
    logic                   w_le  [DEPTH];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) || ((r_state == ST_WAIT) && out_free));
    assign in_accept  = i_in_valid && !o_in_stall;

    assign due_sum = {1'b0, i_now_us} + {{(TIME_W + 1 - DELAY_W){1'b0}}, i_delay_us};

    assign do_add = (r_state == ST_APPLY) && (r_mode == MODE_ADD) && (r_count != FULL_COUNT);
    assign do_pop = (r_state == ST_APPLY) && (r_mode == MODE_POP) && (r_count != '0);
    assign cell_ctrl.insert = do_add;
    assign cell_ctrl.remove = do_pop;

    assign head_wait = ((r_count != '0) && (w_due[0] > r_now)) ? (w_due[0] - r_now) : '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                   prev_le;
        logic [TIME_W-1:0]      prev_due;
        logic [ACTION_BITS-1:0] prev_id;
        logic [TIME_W-1:0]      next_due;
        logic [ACTION_BITS-1:0] next_id;

        if (g == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign prev_due = r_due;
            assign prev_id  = r_id;
        end else begin : g_inner
            assign prev_le  = w_le[g-1];
            assign prev_due = w_due[g-1];
            assign prev_id  = w_id[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_due = w_due[g];
            assign next_id  = w_id[g];
        end else begin : g_body
            assign next_due = w_due[g+1];
            assign next_id  = w_id[g+1];
        end

        taq_cell #(
            .ACTION_BITS(ACTION_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_occ      (CNT_W'(g) < r_count),
            .i_new_due  (r_due),
            .i_new_id   (r_id),
            .i_prev_le  (prev_le),
            .i_prev_due (prev_due),
            .i_prev_id  (prev_id),
            .i_next_due (next_due),
            .i_next_id  (next_id),
            .o_le       (w_le[g]),
            .o_due      (w_due[g]),
            .o_id       (w_id[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state = ST_WAIT;
                if (do_add) begin
                    n_count = r_count + 1'b1;
                end else if (do_pop) begin
                    n_count = r_count - 1'b1;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = in_accept ? ST_APPLY : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_mode;
            r_now  <= i_now_us;
            r_due  <= due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
            r_id   <= i_action_id;
        end
        if (r_state == ST_APPLY) begin
            r_res_pvld <= do_pop;
            r_res_act  <= do_pop ? w_id[0] : '0;
            if ((r_mode == MODE_ADD) && !do_add) begin
                r_res_status <= STATUS_FULL;
            end else if ((r_mode == MODE_POP) && !do_pop) begin
                r_res_status <= STATUS_EMPTY;
            end else begin
                r_res_status <= STATUS_OK;
            end
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_act    <= r_res_act;
            r_out_pvld   <= r_res_pvld;
            r_out_wait   <= head_wait;
            r_out_empty  <= (r_count == '0);
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_popped_action = r_out_act;
    assign o_popped_valid  = r_out_pvld;
    assign o_wait_us       = r_out_wait;
    assign o_is_empty      = r_out_empty;
    assign o_entry_count   = r_out_count;

    `ASSERT_ALWAYS(a_count_bound, r_count <= FULL_COUNT, "occupancy above depth")
    `ASSERT_ALWAYS(a_empty_match, !o_out_valid || (o_is_empty == (o_entry_count == '0)),
        "empty flag disagrees with count")
    `ASSERT_NEXT(a_wait_hold, (r_state == ST_WAIT) && !out_free, r_state == ST_WAIT,
        "result stage left while blocked")
    `ASSERT_NEXT(a_pop_count, do_pop, r_count == $past(r_count) - 1'b1,
        "pop did not reduce occupancy")
    `ASSERT_NEXT(a_add_count, do_add, r_count == $past(r_count) + 1'b1,
        "add did not raise occupancy")

endmodule

`default_nettype wire

// File: rtl/core/taq_cell.sv
`default_nettype none

module taq_cell
    import taq_pkg::*;
#(
    parameter int ACTION_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic                   i_occ,
    input  wire logic [TIME_W-1:0]      i_new_due,
    input  wire logic [ACTION_BITS-1:0] i_new_id,
    input  wire logic                   i_prev_le,
    input  wire logic [TIME_W-1:0]      i_prev_due,
    input  wire logic [ACTION_BITS-1:0] i_prev_id,
    input  wire logic [TIME_W-1:0]      i_next_due,
    input  wire logic [ACTION_BITS-1:0] i_next_id,
    output logic                        o_le,
    output logic [TIME_W-1:0]           o_due,
    output logic [ACTION_BITS-1:0]      o_id
);

    logic [TIME_W-1:0]      r_due;
    logic [TIME_W-1:0]      n_due;
    logic [ACTION_BITS-1:0] r_id;
    logic [ACTION_BITS-1:0] n_id;

    assign o_le  = i_occ && (r_due <= i_new_due);
    assign o_due = r_due;
    assign o_id  = r_id;

    always_comb begin
        n_due = r_due;
        n_id  = r_id;
        if (i_ctrl.insert) begin
            if (!i_prev_le) begin
                n_due = i_prev_due;
                n_id  = i_prev_id;
            end else if (!o_le) begin
                n_due = i_new_due;
                n_id  = i_new_id;
            end
        end else if (i_ctrl.remove) begin
            n_due = i_next_due;
            n_id  = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_due <= n_due;
        r_id  <= n_id;
    end

endmodule

`default_nettype wire
